>>> rtl/bpam_pkg.sv
package bpam_pkg;

   localparam int DIR_SLOTS     = 1024;
   localparam int DIR_WORD_BITS = 32;
   localparam int DIR_WORDS     = DIR_SLOTS / DIR_WORD_BITS;
   localparam int PAGE_SHIFT    = 12;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_RUN    = 2'd1;
   localparam logic [1:0] STATUS_NO_FRAME  = 2'd2;
   localparam logic [1:0] STATUS_BAD_COUNT = 2'd3;

   localparam logic [1:0] CSR_PHYS_BASE  = 2'd0;
   localparam logic [1:0] CSR_HEAP_BASE  = 2'd1;
   localparam logic [1:0] CSR_POOL_PAGES = 2'd2;

   localparam logic [31:0] ENTRY_FLAGS      = 32'h0000_0007;
   localparam logic [31:0] PHYS_BASE_RESET  = 32'h0020_0000;
   localparam logic [31:0] HEAP_BASE_RESET  = 32'hc010_0000;
   localparam logic [12:0] POOL_PAGES_RESET = 13'd4096;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PAGE,
      S_DIR_CHK,
      S_PTE,
      S_FAIL,
      S_OUT_RD,
      S_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic        write_valid;
      logic        is_dir;
      logic [31:0] addr;
      logic [31:0] value;
   } entry_type;

endpackage

>>> rtl/bitmap_page_allocator_mapper.sv
// flow: a rejected request writes its one result in the idle state and replays it through
// S_OUT_RD and S_OUT_WAIT; a granted run passes S_PAGE and S_DIR_CHK for each page, plus S_PTE
// for each new directory slot, then replays each result through S_OUT_RD and S_OUT_WAIT.
// one request at a time: a new one is taken only after every result of the last is handed off.
// frame and page bitmaps only ever fill from the bottom, so they are held as fill counters;
// the directory-present bitmap is a 32 x 32 ram, results are staged in a ram before replay.
// reset: synchronous; a pass through S_CLEAR clears the directory ram, requests are held off meanwhile.
module bitmap_page_allocator_mapper #(
   parameter int POOL_PAGES = 4096,
   parameter int MAX_RUN    = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [5:0] page_count
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [31:0] entry_address, [63:32] entry_value,
                                     // [95:64] start_vaddr, [97:96] status
   output logic [1:0]   rsp_tuser,   // [0] write_valid, [1] entry_is_directory
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);
   import bpam_pkg::*;

   localparam int CW    = $clog2(POOL_PAGES + 1);
   localparam int DEPTH = 2 * MAX_RUN;
   localparam int BW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = $clog2(MAX_RUN + 1);
   localparam int DWW   = $clog2(DIR_WORDS);
   localparam logic [5:0] MaxRunCnt = 6'(MAX_RUN);

   logic [31:0] phys_base_ff, heap_base_ff;
   logic [12:0] pool_pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_base_ff  <= PHYS_BASE_RESET;
         heap_base_ff  <= HEAP_BASE_RESET;
         pool_pages_ff <= POOL_PAGES_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PHYS_BASE:  phys_base_ff  <= csr_wdata;
            CSR_HEAP_BASE:  heap_base_ff  <= csr_wdata;
            CSR_POOL_PAGES: pool_pages_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // usable bits: whole bytes only, capped at the pool size
   logic [12:0] pp_masked;
   logic [CW-1:0] n_pages;
   assign pp_masked = {pool_pages_ff[12:3], 3'b000};
   assign n_pages = (32'(pp_masked) > 32'(POOL_PAGES)) ? CW'(POOL_PAGES) : CW'(pp_masked);

   state_type state_ff, state_in;
   logic [CW-1:0]  vnext_ff, vnext_in, fnext_ff, fnext_in, fidx_ff, fidx_in;
   logic [31:0]    va_ff, va_in, start_ff, start_in;
   logic [1:0]     status_ff, status_in;
   logic [LW-1:0]  left_ff, left_in;
   logic [BW:0]    k_ff, k_in, oidx_ff, oidx_in;
   logic [DWW-1:0] clr_ff, clr_in;

   logic [DIR_WORD_BITS-1:0] dir_ram_ff [DIR_WORDS];
   logic [DIR_WORD_BITS-1:0] dir_q_ff, dir_wdata;
   logic [DWW-1:0]           dir_waddr, dir_raddr;
   logic                     dir_we;

   entry_type buf_ram_ff [DEPTH];
   entry_type buf_q_ff, buf_wdata;
   logic      buf_we;

   always_ff @(posedge clock) begin
      if (dir_we) dir_ram_ff[dir_waddr] <= dir_wdata;
      dir_q_ff <= dir_ram_ff[dir_raddr];
   end

   always_ff @(posedge clock) begin
      if (buf_we) buf_ram_ff[k_ff[BW-1:0]] <= buf_wdata;
      buf_q_ff <= buf_ram_ff[oidx_ff[BW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         vnext_ff  <= '0;
         fnext_ff  <= '0;
         clr_ff    <= '0;
         k_ff      <= '0;
         oidx_ff   <= '0;
         left_ff   <= '0;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         vnext_ff  <= vnext_in;
         fnext_ff  <= fnext_in;
         clr_ff    <= clr_in;
         k_ff      <= k_in;
         oidx_ff   <= oidx_in;
         left_ff   <= left_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      fidx_ff  <= fidx_in;
      va_ff    <= va_in;
      start_ff <= start_in;
   end

   logic [5:0]  cnt;
   logic        frame_free, slot_present;
   entry_type   pte_entry, dir_entry, fail_entry;

   assign cnt          = req_tdata[5:0];
   assign frame_free   = fnext_ff < n_pages;
   assign slot_present = dir_q_ff[va_ff[26:22]];
   assign pte_entry    = '{write_valid: 1'b1, is_dir: 1'b0,
                           addr: {10'h3ff, va_ff[31:12], 2'b00},
                           value: (phys_base_ff + (32'(fidx_ff) << PAGE_SHIFT)) | ENTRY_FLAGS};
   assign dir_entry    = '{write_valid: 1'b1, is_dir: 1'b1,
                           addr: {20'hfffff, va_ff[31:22], 2'b00},
                           value: (phys_base_ff + (32'(fnext_ff) << PAGE_SHIFT)) | ENTRY_FLAGS};
   assign fail_entry   = '0;

   always_comb begin
      state_in  = state_ff;
      vnext_in  = vnext_ff;
      fnext_in  = fnext_ff;
      fidx_in   = fidx_ff;
      va_in     = va_ff;
      start_in  = start_ff;
      status_in = status_ff;
      left_in   = left_ff;
      k_in      = k_ff;
      oidx_in   = oidx_ff;
      clr_in    = clr_ff;
      dir_we    = 1'b0;
      dir_waddr = va_ff[31:27];
      dir_raddr = va_ff[31:27];
      dir_wdata = dir_q_ff | (DIR_WORD_BITS'(1) << va_ff[26:22]);
      buf_we    = 1'b0;
      buf_wdata = pte_entry;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            dir_we    = 1'b1;
            dir_waddr = clr_ff;
            dir_wdata = '0;
            clr_in    = clr_ff + DWW'(1);
            if (clr_ff == DWW'(DIR_WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            k_in       = '0;
            oidx_in    = '0;
            if (req_tvalid) begin
               if (cnt == 6'd0 || cnt > MaxRunCnt) begin
                  buf_we    = 1'b1;
                  buf_wdata = fail_entry;
                  k_in      = (BW + 1)'(1);
                  status_in = STATUS_BAD_COUNT;
                  start_in  = '0;
                  state_in  = S_OUT_RD;
               end else if (32'(vnext_ff) + 32'(cnt) > 32'(n_pages)) begin
                  buf_we    = 1'b1;
                  buf_wdata = fail_entry;
                  k_in      = (BW + 1)'(1);
                  status_in = STATUS_NO_RUN;
                  start_in  = '0;
                  state_in  = S_OUT_RD;
               end else begin
                  start_in  = heap_base_ff + (32'(vnext_ff) << PAGE_SHIFT);
                  va_in     = heap_base_ff + (32'(vnext_ff) << PAGE_SHIFT);
                  vnext_in  = CW'(32'(vnext_ff) + 32'(cnt));
                  left_in   = LW'(cnt);
                  status_in = STATUS_OK;
                  state_in  = S_PAGE;
               end
            end
         end
         S_PAGE: begin
            // directory word read goes out here, checked next cycle
            if (frame_free) begin
               fidx_in  = fnext_ff;
               fnext_in = fnext_ff + CW'(1);
               state_in = S_DIR_CHK;
            end else begin
               state_in = S_FAIL;
            end
         end
         S_DIR_CHK: begin
            if (slot_present) begin
               buf_we  = 1'b1;
               k_in    = k_ff + (BW + 1)'(1);
               va_in   = va_ff + 32'(1 << PAGE_SHIFT);
               left_in = left_ff - LW'(1);
               state_in = (left_ff == LW'(1)) ? S_OUT_RD : S_PAGE;
            end else if (frame_free) begin
               dir_we    = 1'b1;
               buf_we    = 1'b1;
               buf_wdata = dir_entry;
               fnext_in  = fnext_ff + CW'(1);
               k_in      = k_ff + (BW + 1)'(1);
               state_in  = S_PTE;
            end else begin
               state_in = S_FAIL;
            end
         end
         S_PTE: begin
            buf_we  = 1'b1;
            k_in    = k_ff + (BW + 1)'(1);
            va_in   = va_ff + 32'(1 << PAGE_SHIFT);
            left_in = left_ff - LW'(1);
            state_in = (left_ff == LW'(1)) ? S_OUT_RD : S_PAGE;
         end
         S_FAIL: begin
            buf_we    = 1'b1;
            buf_wdata = fail_entry;
            k_in      = k_ff + (BW + 1)'(1);
            status_in = STATUS_NO_FRAME;
            start_in  = '0;
            state_in  = S_OUT_RD;
         end
         S_OUT_RD: begin
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (oidx_ff == k_ff - (BW + 1)'(1)) begin
                  // back to slot 0 so a rejected request in the first idle cycle lands there
                  k_in     = '0;
                  oidx_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  oidx_in  = oidx_ff + (BW + 1)'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tdata = {6'b0, status_ff, start_ff, buf_q_ff.value, buf_q_ff.addr};
   assign rsp_tuser = {buf_q_ff.is_dir, buf_q_ff.write_valid};
   assign rsp_tlast = (oidx_ff == k_ff - (BW + 1)'(1));

endmodule

>>> test/tb.sv
module tb;
   import bpam_pkg::*;

   localparam int POOL_MAX    = 4096;
   localparam int RUN_MAX     = 32;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct {
      logic        write_valid;
      logic        is_dir;
      logic [31:0] addr;
      logic [31:0] value;
      logic [31:0] start_va;
      logic [1:0]  status;
      logic        last;
   } alloc_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we;
   logic [1:0]   csr_addr;
   logic [31:0]  csr_wdata;

   bitmap_page_allocator_mapper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // allocator shadow state
   bit [POOL_MAX-1:0]  virt_used;
   bit [POOL_MAX-1:0]  frame_used;
   bit [DIR_SLOTS-1:0] slot_present;
   logic [31:0]        phys_base;
   logic [31:0]        heap_base;
   logic [12:0]        pool_reg;

   logic [5:0]       pending_counts[$];
   alloc_result_type expected_results[$];

   int  errors, items_sent, results_seen, dir_writes, pte_writes, cycles;
   int  status_seen[4];
   int  burst_left, gap_left, stall_left;
   bit  stall_mode, next_valid;

   function automatic int usable_pages();
      int n;
      n = pool_reg & 13'h1ff8;
      if (n > POOL_MAX) n = POOL_MAX;
      return n;
   endfunction

   function automatic bit grab_frame(output int idx);
      int n;
      n = usable_pages();
      for (int i = 0; i < n; i++) begin
         if (!frame_used[i]) begin
            frame_used[i] = 1'b1;
            idx = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void plan_allocation(input logic [5:0] cnt);
      alloc_result_type writes[$];
      alloc_result_type r;
      logic [1:0]    st;
      logic [31:0]   sva, va;
      int            n, run, first, fidx, tidx, slot;
      bit            found;
      n = usable_pages();
      st = STATUS_OK;
      sva = '0;
      run = 0;
      first = 0;
      found = 0;
      r = '{default: '0};
      if (cnt == 0 || cnt > RUN_MAX) begin
         st = STATUS_BAD_COUNT;
         writes.push_back(r);
      end else begin
         for (int i = 0; i < n && !found; i++) begin
            if (virt_used[i]) run = 0;
            else begin
               run++;
               if (run == cnt) begin
                  first = i + 1 - cnt;
                  found = 1;
               end
            end
         end
         if (!found) begin
            st = STATUS_NO_RUN;
            writes.push_back(r);
         end else begin
            for (int p = 0; p < cnt; p++) virt_used[first + p] = 1'b1;
            sva = heap_base + 32'(first) * 32'd4096;
            va = sva;
            for (int p = 0; p < cnt && st == STATUS_OK; p++) begin
               if (!grab_frame(fidx)) st = STATUS_NO_FRAME;
               else begin
                  slot = va[31:22];
                  if (!slot_present[slot]) begin
                     if (!grab_frame(tidx)) st = STATUS_NO_FRAME;
                     else begin
                        slot_present[slot] = 1'b1;
                        r = '{default: '0};
                        r.write_valid = 1'b1;
                        r.is_dir = 1'b1;
                        r.addr = 32'hfffff000 + 32'(slot) * 32'd4;
                        r.value = (phys_base + 32'(tidx) * 32'd4096) | ENTRY_FLAGS;
                        writes.push_back(r);
                     end
                  end
                  if (st == STATUS_OK) begin
                     r = '{default: '0};
                     r.write_valid = 1'b1;
                     r.addr = 32'hffc00000 + ((va & 32'hffc00000) >> 10)
                            + ((va & 32'h003ff000) >> 12) * 32'd4;
                     r.value = (phys_base + 32'(fidx) * 32'd4096) | ENTRY_FLAGS;
                     writes.push_back(r);
                     va = va + 32'd4096;
                  end
               end
            end
            if (st != STATUS_OK) begin
               r = '{default: '0};
               writes.push_back(r);
            end
         end
      end
      if (st != STATUS_OK) sva = '0;
      foreach (writes[j]) begin
         writes[j].start_va = sva;
         writes[j].status = st;
         writes[j].last = (j == writes.size() - 1);
         expected_results.push_back(writes[j]);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            plan_allocation(pending_counts[0]);
            pending_counts.pop_front();
            items_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) gap_left--;
            else if (pending_counts.size() > 0) begin
               next_valid = 1'b1;
               req_tdata <= {2'b00, pending_counts[0]};
               if (burst_left == 0) burst_left = $urandom_range(1, 12);
               burst_left--;
               if (burst_left == 0)
                  gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // receiver: alternates between always-ready stretches and random stalling
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 1);
         stall_left = $urandom_range(5, 80);
      end else stall_left--;
      rsp_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer: tdata=%h", rsp_tdata);
         end else begin
            alloc_result_type e;
            e = expected_results.pop_front();
            status_seen[e.status]++;
            if (e.write_valid && e.is_dir) dir_writes++;
            if (e.write_valid && !e.is_dir) pte_writes++;
            if (rsp_tuser[0] !== e.write_valid || rsp_tuser[1] !== e.is_dir ||
                rsp_tdata[31:0] !== e.addr || rsp_tdata[63:32] !== e.value ||
                rsp_tdata[95:64] !== e.start_va || rsp_tdata[97:96] !== e.status ||
                rsp_tlast !== e.last) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp wv=%b dir=%b addr=%h val=%h va=%h st=%0d last=%b",
                           e.write_valid, e.is_dir, e.addr, e.value, e.start_va, e.status,
                           e.last, "\n          got wv=%b dir=%b addr=%h val=%h va=%h st=%0d last=%b",
                           rsp_tuser[0], rsp_tuser[1], rsp_tdata[31:0], rsp_tdata[63:32],
                           rsp_tdata[95:64], rsp_tdata[97:96], rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_PHYS_BASE:  phys_base = v;
         CSR_HEAP_BASE:  heap_base = v;
         CSR_POOL_PAGES: pool_reg = v[12:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every request has been sent and answered
   task automatic drain();
      do @(posedge clock);
      while (pending_counts.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [5:0] random_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return 6'd0;
      if (pick < 10) return 6'($urandom_range(33, 63));
      if (pick < 15) return 6'd32;
      if (pick < 25) return 6'($urandom_range(7, 31));
      return 6'($urandom_range(1, 6));
   endfunction

   function automatic logic [31:0] random_base();
      case ($urandom_range(0, 3))
         0: return 32'h0;
         1: return 32'hfffff000;
         default: return {20'($urandom_range(0, 32'hfffff)), 12'h000};
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      virt_used = '0;
      frame_used = '0;
      slot_present = '0;
      phys_base = PHYS_BASE_RESET;
      heap_base = HEAP_BASE_RESET;
      pool_reg = POOL_PAGES_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // tiny pool: bad counts, frames running out mid-run, then no virtual run left
      write_csr(CSR_POOL_PAGES, 32'd16);
      pending_counts.push_back(6'd0);
      pending_counts.push_back(6'd33);
      pending_counts.push_back(6'd63);
      pending_counts.push_back(6'd4);
      pending_counts.push_back(6'd8);
      pending_counts.push_back(6'd4);
      pending_counts.push_back(6'd1);
      drain();
      // grow by eight and use seven of them in the same directory slot
      write_csr(CSR_POOL_PAGES, 32'd24);
      pending_counts.push_back(6'd7);
      drain();
      // new slot with one frame left: page frame taken, no frame for the table
      write_csr(CSR_HEAP_BASE, 32'h4000_0000);
      pending_counts.push_back(6'd1);
      drain();
      // wrapping addresses, pool value above the cap
      write_csr(CSR_PHYS_BASE, 32'hfffff000);
      write_csr(CSR_HEAP_BASE, 32'hffff0000);
      write_csr(CSR_POOL_PAGES, 32'd8191);
      pending_counts.push_back(6'd32);
      pending_counts.push_back(6'd1);
      pending_counts.push_back(6'd2);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_PHYS_BASE, random_base());
         write_csr(CSR_HEAP_BASE, random_base());
         write_csr(CSR_POOL_PAGES, (ph % 2) ? 32'd4096 : 32'd4103);
         repeat (75) pending_counts.push_back(random_count());
         drain();
      end

      // empty pool
      write_csr(CSR_POOL_PAGES, 32'd0);
      pending_counts.push_back(6'd1);
      pending_counts.push_back(6'd0);
      drain();

      $display("%0d requests, %0d results: %0d table writes, %0d directory writes",
               items_sent, results_seen, pte_writes, dir_writes);
      $display("result status ok/no-run/no-frame/bad-count: %0d/%0d/%0d/%0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", errors);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
